### rtl/olst_pkg.sv
// Shared codes and widths for the ordered list engine.
// Command and status codes, field widths. No dependencies.
`default_nettype none

package olst_pkg;

    // Field widths
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;

    // Command codes (carried in s_tuser)
    localparam logic [OP_W-1:0] OP_INS_HEAD   = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_TAIL   = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_ANCHOR = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_HEAD   = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_TAIL   = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_VALUE  = 3'd5;
    localparam logic [OP_W-1:0] OP_READ_OUT   = 3'd6;

    // Status codes (carried in m_tuser[1:0])
    localparam logic [ST_W-1:0] ST_DONE     = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

endpackage

`default_nettype wire

### rtl/olst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
`default_nettype none

module olst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/ordered_list_engine.sv
// Ordered list engine top level: command sequencer, shared compare/shift walk.
// Depends on olst_pkg and olst_ram.
//
// Usage:
//   Slave channel takes one command item: s_tuser = op, s_tdata = {anchor_value, value}.
//   Master channel returns result items: m_tdata = elem_value,
//   m_tuser = {list_empty, status}, m_tlast = last result of the command.
//   The list lives in a DEPTH x 32 RAM; one sequencer walks it with a single
//   comparator and one address pointer, one entry per cycle in search and shift walks.
//   s_tready is high only while the sequencer is idle; one command at a time.
//   Insert/delete at head or tail runs the RAM shift walk, one entry per cycle,
//   pipelined through the read register; the anchor/value commands add a search
//   ahead of it, and a search hit hands over straight to the shift walk. Read out
//   handles one element at a time: read issue, then registered read data, then
//   the result is handed over before the next read is issued.
//   Results pass through one output register, so the next command is accepted
//   while a status result still waits on m_tready; a stalled receiver holds the
//   sequencer only when it has a new result to hand over.
//   Reset clears the element count and control state; RAM contents are not
//   cleared, and only entries below the count are ever read.

`default_nettype none

module ordered_list_engine
    import olst_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Command items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] value, [63:32] anchor_value
    input  logic [2:0]  s_tuser,   // [2:0] op
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] elem_value
    output logic [2:0]  m_tuser,   // [1:0] status, [2] list_empty
    output logic        m_tlast
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_EMIT,
        S_RD_ISSUE,
        S_RD_WAIT
    } state_t;

    state_t            state_reg,   state_next;
    logic [OP_W-1:0]   op_reg,      op_next;
    logic [DATA_W-1:0] value_reg,   value_next;
    logic [DATA_W-1:0] key_reg,     key_next;
    logic [CW-1:0]     count_reg,   count_next;
    logic [AW-1:0]     ptr_reg,     ptr_next;
    logic [CW-1:0]     rem_reg,     rem_next;
    logic [AW-1:0]     pos_reg,     pos_next;
    logic              rd_vld_reg,  rd_vld_next;
    logic [AW-1:0]     rd_addr_reg, rd_addr_next;
    logic [ST_W-1:0]   status_reg,  status_next;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg,  m_data_next;
    logic [2:0]        m_user_reg,  m_user_next;
    logic              m_last_reg,  m_last_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;

    logic              out_free;
    logic              start_shift;
    logic [AW-1:0]     start_pos;
    logic [OP_W-1:0]   act_op;
    logic              ins;
    logic              is_full;
    logic              is_empty;
    logic              rd_last;

    olst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign is_full  = (count_reg == FULL_CNT);
    assign is_empty = (count_reg == '0);
    assign rd_last  = (CW'(ptr_reg) == count_reg - CW'(1));

    // Command in flight: the arriving one while idle, else the latched one
    assign act_op = (state_reg == S_IDLE) ? s_tuser : op_reg;
    assign ins    = (act_op == OP_INS_HEAD) || (act_op == OP_INS_TAIL)
                 || (act_op == OP_INS_ANCHOR);

    // Sequencer next-state logic
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        value_next   = value_reg;
        key_next     = key_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        rem_next     = rem_reg;
        pos_next     = pos_reg;
        rd_vld_next  = rd_vld_reg;
        rd_addr_next = rd_addr_reg;
        status_next  = status_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_valid_reg && !m_tready;
        ram_we       = 1'b0;
        ram_waddr    = rd_addr_reg;
        ram_wdata    = ram_rdata;
        start_shift  = 1'b0;
        start_pos    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser;
                    value_next = s_tdata[31:0];
                    key_next   = (s_tuser == OP_INS_ANCHOR) ? s_tdata[63:32] : s_tdata[31:0];
                    unique case (s_tuser)
                        OP_INS_HEAD, OP_INS_TAIL:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                start_shift = 1'b1;
                                start_pos   = (s_tuser == OP_INS_HEAD) ? '0
                                                                       : count_reg[AW-1:0];
                            end
                        end
                        OP_INS_ANCHOR, OP_DEL_VALUE:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                ptr_next    = '0;
                                rem_next    = count_reg;
                                rd_vld_next = 1'b0;
                                state_next  = S_SEARCH;
                            end
                        end
                        OP_DEL_HEAD, OP_DEL_TAIL:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                start_shift = 1'b1;
                                start_pos   = (s_tuser == OP_DEL_HEAD) ? '0
                                                                       : AW'(count_reg - CW'(1));
                            end
                        end
                        OP_READ_OUT:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_RD_ISSUE;
                            end
                        end
                        default:
                        begin
                            // Unused opcode: drop without a result
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                // Issue the next read while entries remain
                if (rem_reg != '0)
                begin
                    rd_vld_next  = 1'b1;
                    rd_addr_next = ptr_reg;
                    ptr_next     = ptr_reg + AW'(1);
                    rem_next     = rem_reg - CW'(1);
                end
                else
                begin
                    rd_vld_next = 1'b0;
                end
                // Compare the entry read last cycle
                if (rd_vld_reg)
                begin
                    if (ram_rdata == key_reg)
                    begin
                        if (ins && is_full)
                        begin
                            status_next = ST_FULL;
                            rd_vld_next = 1'b0;
                            state_next  = S_EMIT;
                        end
                        else
                        begin
                            start_shift = 1'b1;
                            start_pos   = rd_addr_reg;
                        end
                    end
                    else if (CW'(rd_addr_reg) == count_reg - CW'(1))
                    begin
                        status_next = ST_NOTFOUND;
                        rd_vld_next = 1'b0;
                        state_next  = S_EMIT;
                    end
                end
            end

            S_SHIFT:
            begin
                // Read one entry per cycle, toward pos on insert, away from pos on delete
                if (rem_reg != '0)
                begin
                    rd_vld_next  = 1'b1;
                    rd_addr_next = ptr_reg;
                    ptr_next     = ins ? ptr_reg - AW'(1) : ptr_reg + AW'(1);
                    rem_next     = rem_reg - CW'(1);
                end
                else
                begin
                    rd_vld_next = 1'b0;
                end
                // Write it back one place over
                if (rd_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ins ? rd_addr_reg + AW'(1) : rd_addr_reg - AW'(1);
                    ram_wdata = ram_rdata;
                end
                // Walk drained: place the new value or drop one entry
                if ((rem_reg == '0) && !rd_vld_reg)
                begin
                    if (ins)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = pos_reg;
                        ram_wdata  = value_reg;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    status_next = ST_DONE;
                    state_next  = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_user_next  = {(op_reg == OP_READ_OUT), status_reg};
                    m_last_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            S_RD_ISSUE:
            begin
                state_next = S_RD_WAIT;
            end

            S_RD_WAIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = ram_rdata;
                    m_user_next  = {1'b0, ST_DONE};
                    m_last_next  = rd_last;
                    if (rd_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + AW'(1);
                        state_next = S_RD_ISSUE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Set up the shift walk around start_pos
        if (start_shift)
        begin
            state_next  = S_SHIFT;
            rd_vld_next = 1'b0;
            pos_next    = start_pos;
            if (ins)
            begin
                ptr_next = AW'(count_reg - CW'(1));
                rem_next = count_reg - CW'(start_pos);
            end
            else
            begin
                ptr_next = start_pos + AW'(1);
                rem_next = count_reg - CW'(start_pos) - CW'(1);
            end
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            op_reg      <= '0;
            value_reg   <= '0;
            key_reg     <= '0;
            count_reg   <= '0;
            ptr_reg     <= '0;
            rem_reg     <= '0;
            pos_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            rd_addr_reg <= '0;
            status_reg  <= ST_DONE;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            m_user_reg  <= '0;
            m_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            value_reg   <= value_next;
            key_reg     <= key_next;
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            rem_reg     <= rem_next;
            pos_reg     <= pos_next;
            rd_vld_reg  <= rd_vld_next;
            rd_addr_reg <= rd_addr_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
            m_data_reg  <= m_data_next;
            m_user_reg  <= m_user_next;
            m_last_reg  <= m_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // Element count never exceeds capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("element count above capacity");

    // Empty read-out result is a single, zero, final item
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_user_reg[2]) |->
            (m_last_reg && (m_user_reg[1:0] == ST_EMPTY) && (m_data_reg == '0)))
        else $error("malformed empty read-out result");

    // A pending status result waits while the output is blocked
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT) && m_valid_reg && !m_tready) |=> (state_reg == S_EMIT))
        else $error("status result dropped under back-pressure");

    // The list store is only written during a shift walk
    a_write_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_SHIFT))
        else $error("list store written outside shift walk");

endmodule

`default_nettype wire
